FILE: hdl/hte_pkg.sv
// Package with shared types, constants and helpers of the homogeneous transform engine.
`default_nettype none
package hte_pkg;
   localparam int DEFAULT_FRAC_BITS = 16;
   localparam int DEFAULT_DIM = 4;
   localparam int WORD_W = 32;
   localparam int DIV_STEPS = 64;
   // Four floored products of up to 2^54 each (at the smallest fraction width) fit here.
   localparam int ACC_W = 58;

   localparam logic [1:0] REQ_IDENTITY  = 2'd0;
   localparam logic [1:0] REQ_TRANSLATE = 2'd1;
   localparam logic [1:0] REQ_SCALE     = 2'd2;
   localparam logic [1:0] REQ_POINT     = 2'd3;

   localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh80000000;

   // Lane command from the sequencer.
   typedef struct packed {
      logic clear;
      logic mac;
      logic save;
   } lane_ctl_type;

   // Saturate a wide accumulator sum to 32 bits.
   function automatic logic signed [WORD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
      logic signed [WORD_W-1:0] r;
      begin
         if (v > ACC_W'(S32_MAX)) r = S32_MAX;
         else if (v < ACC_W'(S32_MIN)) r = S32_MIN;
         else r = v[WORD_W-1:0];
         return r;
      end
   endfunction
endpackage
`default_nettype wire

FILE: hdl/hte_lane.sv
// One multiply-accumulate lane: floor-shifted product into a wide sum, saturated to 32 bits at the output.
`default_nettype none
module hte_lane #(
   parameter int FRAC_BITS = hte_pkg::DEFAULT_FRAC_BITS
) (
   input  wire logic                      clock,
   input  wire hte_pkg::lane_ctl_type     ctl,
   input  wire logic signed [31:0]        mul_a,
   input  wire logic signed [31:0]        mul_b,
   output logic signed [31:0]             result
);
   localparam int AW = hte_pkg::ACC_W;

   logic signed [63:0]   prod_ff, prod_in;
   logic                 prod_v_ff;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] term;

   // Arithmetic shift floors the product toward minus infinity.
   assign prod_in = mul_a * mul_b;
   assign term = AW'(prod_ff >>> FRAC_BITS);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) acc_in = '0;
      else if (prod_v_ff) acc_in = acc_ff + term;
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      prod_v_ff <= ctl.mac;
      acc_ff    <= acc_in;
   end

   assign result = hte_pkg::sat_acc(acc_ff);
endmodule
`default_nettype wire

FILE: hdl/hte_div.sv
// Restoring divider, one quotient bit per cycle, with signed saturation.
`default_nettype none
module hte_div #(
   parameter int FRAC_BITS = hte_pkg::DEFAULT_FRAC_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic                    done,
   output logic signed [31:0]      quot
);
   logic [63:0] n_ff, n_in;
   logic [64:0] r_ff, r_in;
   logic [63:0] q_ff, q_in;
   logic [31:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;
   logic signed [64:0] sq;
   logic signed [63:0] nn;

   always_comb begin
      nn = 64'(num) <<< FRAC_BITS;
      n_in = n_ff; r_in = r_ff; q_in = q_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[63:0], n_ff[63]};
      if (go) begin
         n_in = nn[63] ? 64'(-nn) : nn;
         d_in = den[31] ? 32'(-den) : den;
         neg_in = nn[63] ^ den[31];
         r_in = '0; q_in = '0; cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {33'd0, d_ff}) begin
            r_in = trial - {33'd0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
         n_in = {n_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(hte_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      n_ff <= n_in; r_ff <= r_in; q_ff <= q_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   always_comb begin
      sq = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      if (sq > 65'sh7fffffff) quot = hte_pkg::S32_MAX;
      else if (sq < -65'sh80000000) quot = hte_pkg::S32_MIN;
      else quot = sq[31:0];
   end
   assign done = done_ff;
endmodule
`default_nettype wire

FILE: hdl/homogeneous_transform_engine.sv
// Top level of the homogeneous transform engine: sequencer, matrix store, lanes, divider.
`default_nettype none
// A command is taken when start is high and busy is low; busy stays high until the
// command is finished. Four multiply-accumulate lanes each own one row of the result,
// so one pass over the shared index k builds a full output column (four products, a
// pipeline flush in the wait state, one save); a composition walks all four columns
// with busy high. A point needs one column pass and then three divisions on one
// shared radix-2 divider, each made of a launch, 64 steps and a done strobe; a point
// whose w is zero skips the divisions. Set identity never raises busy. Only a point
// gives a result: it appears for one cycle with rsp_valid high, in the first cycle
// in which busy is low again; it cannot be stalled.
module homogeneous_transform_engine #(
   parameter int FRAC_BITS = hte_pkg::DEFAULT_FRAC_BITS,
   parameter int DIM = hte_pkg::DEFAULT_DIM
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_type,
   input  wire logic               req_post_multiply,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   input  wire logic signed [31:0] req_operand_c,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic                    rsp_w_zero
);
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic [2:0] ST_IDLE = 3'd0, ST_MAC = 3'd1, ST_WAIT = 3'd2,
                          ST_SAVE = 3'd3, ST_DIV = 3'd4, ST_DWAIT = 3'd5;

   logic [2:0] st_ff, st_in;
   logic signed [31:0] m_ff [DIM][DIM];
   logic signed [31:0] e_ff [DIM][DIM];
   logic signed [31:0] newm_ff [DIM][DIM];
   logic post_ff, pt_ff;
   logic [1:0] k_ff, k_in, col_ff, col_in;
   logic [2:0] fl_ff, fl_in;
   logic [1:0] dix_ff, dix_in;
   logic signed [31:0] res_ff [DIM];
   logic signed [31:0] q_ff [3];
   hte_pkg::lane_ctl_type ctl;
   logic signed [31:0] lane_res [DIM];
   logic signed [31:0] la [DIM];
   logic signed [31:0] lb [DIM];
   logic div_go, div_done;
   logic signed [31:0] div_q, div_num;
   logic vld_ff, wz_ff;

   // Operand routing: lane r forms row r; left factor L[r][k], right factor R[k][col].
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         if (pt_ff) begin
            la[r] = m_ff[r][k_ff];
            lb[r] = e_ff[k_ff][0];
         end else if (post_ff) begin
            la[r] = m_ff[r][k_ff];
            lb[r] = e_ff[k_ff][col_ff];
         end else begin
            la[r] = e_ff[r][k_ff];
            lb[r] = m_ff[k_ff][col_ff];
         end
      end
   end

   for (genvar g = 0; g < DIM; g++) begin : g_lane
      hte_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .ctl(ctl), .mul_a(la[g]), .mul_b(lb[g]), .result(lane_res[g]));
   end

   assign div_num = res_ff[dix_ff];
   hte_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .go(div_go), .num(div_num), .den(res_ff[3]),
      .done(div_done), .quot(div_q));

   always_comb begin
      st_in = st_ff; k_in = k_ff; col_in = col_ff; fl_in = fl_ff; dix_in = dix_ff;
      ctl = '0; div_go = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (start && req_type != hte_pkg::REQ_IDENTITY) begin
               st_in = ST_MAC; k_in = '0; col_in = '0;
               ctl.clear = 1'b1;
            end
         end
         ST_MAC: begin
            ctl.mac = 1'b1;
            k_in = k_ff + 2'd1;
            if (k_ff == 2'(DIM - 1)) begin
               st_in = ST_WAIT; fl_in = '0;
            end
         end
         ST_WAIT: begin
            fl_in = fl_ff + 3'd1;
            if (fl_ff == 3'd1) st_in = ST_SAVE;
         end
         ST_SAVE: begin
            ctl.save = 1'b1;
            ctl.clear = 1'b1;
            if (pt_ff) begin
               dix_in = '0;
               st_in = ST_DIV;
            end else if (col_ff == 2'(DIM - 1)) st_in = ST_IDLE;
            else begin
               col_in = col_ff + 2'd1; st_in = ST_MAC;
            end
         end
         ST_DIV: begin
            if (res_ff[3] == 0) st_in = ST_IDLE;
            else begin
               div_go = 1'b1; st_in = ST_DWAIT;
            end
         end
         ST_DWAIT: begin
            if (div_done) begin
               dix_in = dix_ff + 2'd1;
               st_in = (dix_ff == 2'd2) ? ST_IDLE : ST_DIV;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; vld_ff <= 1'b0;
         for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++) m_ff[r][c] <= (r == c) ? ONE : '0;
      end else begin
         st_ff <= st_in;
         vld_ff <= 1'b0;
         if (st_ff == ST_IDLE && start) begin
            if (req_type == hte_pkg::REQ_IDENTITY)
               for (int r = 0; r < DIM; r++)
                  for (int c = 0; c < DIM; c++) m_ff[r][c] <= (r == c) ? ONE : '0;
         end
         if (ctl.save && !pt_ff && col_ff == 2'(DIM - 1))
            for (int r = 0; r < DIM; r++)
               for (int c = 0; c < DIM; c++)
                  m_ff[r][c] <= (c == DIM - 1) ? lane_res[r] : newm_ff[r][c];
         if (st_ff == ST_DIV && res_ff[3] == 0) begin
            vld_ff <= 1'b1; wz_ff <= 1'b1;
            q_ff[0] <= '0; q_ff[1] <= '0; q_ff[2] <= '0;
         end
         if (st_ff == ST_DWAIT && div_done && dix_ff == 2'd2) begin
            vld_ff <= 1'b1; wz_ff <= 1'b0;
         end
      end
      k_ff <= k_in; col_ff <= col_in; fl_ff <= fl_in; dix_ff <= dix_in;
      if (st_ff == ST_IDLE && start) begin
         post_ff <= req_post_multiply;
         pt_ff <= (req_type == hte_pkg::REQ_POINT);
         for (int r = 0; r < DIM; r++)
            for (int c = 0; c < DIM; c++) e_ff[r][c] <= (r == c) ? ONE : '0;
         if (req_type == hte_pkg::REQ_TRANSLATE) begin
            e_ff[0][DIM-1] <= req_operand_a;
            e_ff[1][DIM-1] <= req_operand_b;
            e_ff[2][DIM-1] <= req_operand_c;
         end else if (req_type == hte_pkg::REQ_SCALE) begin
            e_ff[0][0] <= req_operand_a;
            e_ff[1][1] <= req_operand_b;
            e_ff[2][2] <= req_operand_c;
         end else if (req_type == hte_pkg::REQ_POINT) begin
            // The point is held as column 0 of the elementary store.
            e_ff[0][0] <= req_operand_a;
            e_ff[1][0] <= req_operand_b;
            e_ff[2][0] <= req_operand_c;
            e_ff[3][0] <= ONE;
         end
      end
      if (ctl.save)
         for (int r = 0; r < DIM; r++) begin
            newm_ff[r][col_ff] <= lane_res[r];
            res_ff[r] <= lane_res[r];
         end
      if (st_ff == ST_DWAIT && div_done) q_ff[dix_ff] <= div_q;
   end

   assign busy = (st_ff != ST_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_out_x = q_ff[0];
   assign rsp_out_y = q_ff[1];
   assign rsp_out_z = q_ff[2];
   assign rsp_w_zero = wz_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");
   a_wz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_w_zero) |-> (rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0))
      else $error("w zero with coordinates");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy after result");
endmodule
`default_nettype wire
